FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the packet header checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/phcrc_pkg.sv
// ----------------------------------------------------------------------------
// phcrc_pkg
// Types, constants and the byte-wide CRC-16 update for the header checker.
// ----------------------------------------------------------------------------
package phcrc_pkg;

	localparam logic [15:0] CRC_START = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	localparam logic [2:0] IDX_NONE   = 3'd0;
	localparam logic [2:0] IDX_ID     = 3'd1;
	localparam logic [2:0] IDX_LEN    = 3'd2;
	localparam logic [2:0] IDX_CRC_LO = 3'd3;
	localparam logic [2:0] IDX_CRC_HI = 3'd4;

	typedef struct packed {
		logic       header_ok;
		logic       crc_ok;
		logic [7:0] packet_id;
		logic [7:0] payload_length;
	} result_t;

	// CRC-16-CCITT, MSB first, one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/phcrc_core.sv
// ----------------------------------------------------------------------------
// phcrc_core
// Packet state: header capture, LRC check and running payload CRC.
// ----------------------------------------------------------------------------
module phcrc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [7:0]         data_byte,
	input  logic               start_req,
	output logic               res_valid,
	output phcrc_pkg::result_t res
);
	import phcrc_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [7:0]  lrc_q, lrc_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] exp_q, exp_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  lrc_calc;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		lrc_d     = lrc_q;
		sum_d     = sum_q;
		id_d      = id_q;
		len_d     = len_q;
		exp_d     = exp_q;
		crc_d     = crc_q;
		cnt_d     = cnt_q;
		lrc_calc  = 8'd0;
		res_valid = 1'b0;
		res       = '{header_ok: 1'b0, crc_ok: 1'b0, packet_id: id_q, payload_length: len_q};
		if (start_req) begin
			lrc_d   = data_byte;
			sum_d   = 8'd0;
			idx_d   = IDX_ID;
			phase_d = PH_HEADER;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					sum_d = sum_q + data_byte;
					case (idx_q)
						IDX_ID: begin
							id_d  = data_byte;
							idx_d = IDX_LEN;
						end
						IDX_LEN: begin
							len_d = data_byte;
							idx_d = IDX_CRC_LO;
						end
						IDX_CRC_LO: begin
							exp_d = {exp_q[15:8], data_byte};
							idx_d = IDX_CRC_HI;
						end
						default: begin
							exp_d    = {data_byte, exp_q[7:0]};
							idx_d    = IDX_NONE;
							lrc_calc = 8'd0 - sum_d;
							if ((lrc_calc != lrc_q) || (len_q == 8'd0)) begin
								phase_d   = PH_IDLE;
								res_valid = 1'b1;
							end else begin
								crc_d   = CRC_START;
								cnt_d   = 8'd0;
								phase_d = PH_PAYLOAD;
							end
						end
					endcase
				end
				PH_PAYLOAD: begin
					crc_d = crc_byte(crc_q, data_byte);
					cnt_d = cnt_q + 8'd1;
					if (cnt_d == len_q) begin
						phase_d       = PH_IDLE;
						res_valid     = 1'b1;
						res.header_ok = 1'b1;
						res.crc_ok    = (crc_d == exp_q);
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		res_valid = res_valid & in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= IDX_NONE;
			lrc_q   <= 8'd0;
			sum_q   <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 8'd0;
			exp_q   <= 16'd0;
			crc_q   <= CRC_START;
			cnt_q   <= 8'd0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			lrc_q   <= lrc_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			crc_q   <= crc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: rtl/phcrc_obuf.sv
// ----------------------------------------------------------------------------
// phcrc_obuf
// Result register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module phcrc_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  phcrc_pkg::result_t push_res,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_ready,
	output phcrc_pkg::result_t out_res
);
	import phcrc_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				out_valid_q <= 1'b0;
			end
		end else if (out_valid_q) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else if (push) begin
			out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_res;
			end
		end else if (out_valid_q) begin
			if (push) begin
				skid_q <= push_res;
			end
		end else if (push) begin
			out_q <= push_res;
		end
	end

endmodule

FILE: rtl/packet_header_lrc_crc16_checker_top.sv
// ----------------------------------------------------------------------------
// packet_header_lrc_crc16_checker_top
// Byte-stream packet checker: header LRC test and CRC-16-CCITT of the payload.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one stream byte per request,
// with start_req marking the LRC byte that opens a packet header. The header
// is LRC, id, length, CRC low, CRC high. The output channel (out_valid/
// out_ready) carries one result per packet: at once after a failed header,
// or after the last payload byte when the header passed.
// A byte is taken in every cycle while in_ready is high; the packet state and
// the CRC update sit between the packet state registers and the result register,
// and a result passes through the result register (or the skid entry) to out_valid.
// A result register plus one skid entry decouple the sides: in_ready drops
// only when both hold results the receiver has not taken. Reset clears the
// packet state to idle and empties both result entries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_header_lrc_crc16_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       start_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       header_ok,
	output logic       crc_ok,
	output logic [7:0] packet_id,
	output logic [7:0] payload_length
);
	import phcrc_pkg::*;

	logic    in_fire;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_fire = in_valid && in_ready;

	phcrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.data_byte (data_byte),
		.start_req (start_req),
		.res_valid (res_valid),
		.res       (res)
	);

	phcrc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign header_ok      = out_res.header_ok;
	assign crc_ok         = out_res.crc_ok;
	assign packet_id      = out_res.packet_id;
	assign payload_length = out_res.payload_length;

	`ASSERT_IMPLIES(a_stall_needs_out, clk, arst_n, !in_ready, out_valid)
	`ASSERT_NEXT(a_skid_holds, clk, arst_n, out_valid && !out_ready && !in_ready, !in_ready)
	`ASSERT_NEXT(a_fill_skid, clk, arst_n, res_valid && out_valid && !out_ready, !in_ready)
	`ASSERT_IMPLIES(a_fail_no_crc, clk, arst_n, res_valid && !res.header_ok, !res.crc_ok)

endmodule

FILE: dv/pkt_result_checker.sv
// ----------------------------------------------------------------------------
// pkt_result_checker
// Watches both request channels of the packet header checker, predicts the
// verdict of every packet from the accepted bytes and compares each verdict
// the block hands out against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
package pkt_stream_pkg;

	// CRC-16-CCITT, MSB first, one message bit per step.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		logic        fb;
		acc = crc;
		for (int i = 7; i >= 0; i--) begin
			fb  = acc[15] ^ b[i];
			acc = {acc[14:0], 1'b0} ^ (fb ? phcrc_pkg::CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

endpackage

module pkt_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       start_req,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       header_ok,
	input  logic       crc_ok,
	input  logic [7:0] packet_id,
	input  logic [7:0] payload_length,
	output int         mismatches,
	output int         pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import phcrc_pkg::*;
	import pkt_stream_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_HEADER  = 2'd1,
		ST_PAYLOAD = 2'd2
	} scan_state_t;

	scan_state_t scan;
	logic [2:0]  hdr_idx;
	logic [7:0]  lrc_rx;
	logic [7:0]  hdr_sum;
	logic [7:0]  pkt_id;
	logic [7:0]  pkt_len;
	logic [15:0] crc_want;
	logic [15:0] crc_run;
	logic [7:0]  pay_cnt;

	result_t verdict_q[$];
	result_t due;
	result_t seen;

	function automatic bit take_byte(input logic [7:0] b, input logic sop, output result_t r);
		logic [7:0] lrc_calc;
		r = '0;
		take_byte = 1'b0;
		if (sop) begin
			lrc_rx  = b;
			hdr_sum = '0;
			hdr_idx = IDX_ID;
			scan    = ST_HEADER;
		end else if (scan == ST_HEADER) begin
			hdr_sum = hdr_sum + b;
			case (hdr_idx)
				IDX_ID: begin
					pkt_id  = b;
					hdr_idx = IDX_LEN;
				end
				IDX_LEN: begin
					pkt_len = b;
					hdr_idx = IDX_CRC_LO;
				end
				IDX_CRC_LO: begin
					crc_want[7:0] = b;
					hdr_idx       = IDX_CRC_HI;
				end
				default: begin
					crc_want[15:8] = b;
					hdr_idx        = IDX_NONE;
					lrc_calc       = 8'd0 - hdr_sum;
					if (lrc_calc != lrc_rx || pkt_len == 8'd0) begin
						scan             = ST_IDLE;
						r.header_ok      = 1'b0;
						r.crc_ok         = 1'b0;
						r.packet_id      = pkt_id;
						r.payload_length = pkt_len;
						take_byte        = 1'b1;
					end else begin
						crc_run = CRC_START;
						pay_cnt = '0;
						scan    = ST_PAYLOAD;
					end
				end
			endcase
		end else if (scan == ST_PAYLOAD) begin
			crc_run = crc16_step(crc_run, b);
			pay_cnt = pay_cnt + 8'd1;
			if (pay_cnt == pkt_len) begin
				scan             = ST_IDLE;
				r.header_ok      = 1'b1;
				r.crc_ok         = (crc_run == crc_want);
				r.packet_id      = pkt_id;
				r.payload_length = pkt_len;
				take_byte        = 1'b1;
			end
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan       = ST_IDLE;
			hdr_idx    = IDX_NONE;
			lrc_rx     = '0;
			hdr_sum    = '0;
			pkt_id     = '0;
			pkt_len    = '0;
			crc_want   = '0;
			crc_run    = CRC_START;
			pay_cnt    = '0;
			verdict_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (take_byte(data_byte, start_req, due)) begin
					verdict_q.push_back(due);
				end
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("verdict with no packet outstanding: id %0d, length %0d",
						packet_id, payload_length);
					mismatches++;
				end else begin
					seen = verdict_q.pop_front();
					check_field("header_ok", seen.header_ok, header_ok);
					check_field("crc_ok", seen.crc_ok, crc_ok);
					check_field("packet_id", seen.packet_id, packet_id);
					check_field("payload_length", seen.payload_length, payload_length);
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of packets into the header checker: a short directed
// set of packets, then mostly well-formed packets with random content mixed
// with broken headers, bad CRCs, restarts and stray bytes. Both channels
// idle at random; the checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import phcrc_pkg::*;
	import pkt_stream_pkg::*;

	typedef enum int {
		PK_GOOD,
		PK_BAD_CRC,
		PK_BAD_LRC
	} packet_kind_t;

	typedef enum int {
		RX_OPEN,
		RX_MASK,
		RX_RANDOM
	} rx_mode_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       start_req = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       header_ok;
	logic       crc_ok;
	logic [7:0] packet_id;
	logic [7:0] payload_length;

	int mismatches;
	int pending;

	int          burst_left   = 0;
	int          bytes_sent   = 0;
	int          big_left     = 3;
	rx_mode_t    rx_mode      = RX_OPEN;
	int unsigned rx_left      = 0;
	logic [15:0] rx_mask      = '1;

	packet_header_lrc_crc16_checker_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.header_ok      (header_ok),
		.crc_ok         (crc_ok),
		.packet_id      (packet_id),
		.payload_length (payload_length)
	);

	pkt_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.header_ok      (header_ok),
		.crc_ok         (crc_ok),
		.packet_id      (packet_id),
		.payload_length (payload_length),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 80);
			rx_mask = 16'($urandom);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_MASK: begin
				out_ready <= rx_mask[rx_left % 16];
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		endcase
	end

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			return $urandom_range(1, 12);
		end else if (r < 97 || big_left == 0) begin
			return $urandom_range(13, 64);
		end
		big_left--;
		return (big_left == 2) ? 255 : $urandom_range(200, 255);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_byte(input logic [7:0] b, input logic sop);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 7);
			end
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		start_req <= sop;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// cut < 0 sends the whole packet (just the header if that fails); otherwise at most its first cut bytes.
	task automatic send_packet(input logic [7:0] id, input int len, input packet_kind_t kind,
		input int cut);
		logic [7:0]  body[$];
		logic [7:0]  len8;
		logic [15:0] crc;
		logic [7:0]  lrc;
		int          total;
		body = {};
		len8 = len[7:0];
		crc  = CRC_START;
		for (int i = 0; i < len; i++) begin
			body.push_back(random_byte());
			crc = crc16_step(crc, body[i]);
		end
		if (kind == PK_BAD_CRC) begin
			crc = crc ^ 16'($urandom_range(1, 65535));
		end
		lrc = 8'd0 - (id + len8 + crc[7:0] + crc[15:8]);
		if (kind == PK_BAD_LRC) begin
			lrc = lrc ^ 8'($urandom_range(1, 255));
		end
		body.push_front(crc[15:8]);
		body.push_front(crc[7:0]);
		body.push_front(len8);
		body.push_front(id);
		body.push_front(lrc);
		total = (kind == PK_BAD_LRC || len == 0) ? 5 : body.size();
		if (cut >= 0 && cut < total) begin
			total = cut;
		end
		for (int i = 0; i < total; i++) begin
			push_byte(body[i], i == 0);
		end
	endtask

	initial begin
		int pick;
		int len;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_byte(8'hFF, 1'b0);
		send_packet(8'h00, 1, PK_GOOD, -1);
		send_packet(8'hFF, 0, PK_GOOD, -1);
		send_packet(8'hA5, 2, PK_BAD_LRC, -1);
		send_packet(8'h5A, 3, PK_GOOD, 6);
		send_packet(8'h81, 1, PK_BAD_CRC, -1);

		while (bytes_sent < 550) begin
			pick = $urandom_range(0, 99);
			len  = pick_length();
			if (pick < 50) begin
				send_packet(8'($urandom), len, PK_GOOD, -1);
			end else if (pick < 65) begin
				send_packet(8'($urandom), len, PK_BAD_CRC, -1);
			end else if (pick < 75) begin
				send_packet(8'($urandom), $urandom_range(0, 255), PK_BAD_LRC, -1);
			end else if (pick < 80) begin
				send_packet(8'($urandom), 0, PK_GOOD, -1);
			end else if (pick < 90) begin
				send_packet(8'($urandom), len, PK_GOOD, $urandom_range(1, len + 4));
			end else begin
				repeat ($urandom_range(1, 3)) push_byte(random_byte(), 1'b0);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: packet_header_lrc_crc16_checker_top.f
+incdir+rtl
rtl/phcrc_pkg.sv
rtl/phcrc_core.sv
rtl/phcrc_obuf.sv
rtl/packet_header_lrc_crc16_checker_top.sv
dv/pkt_result_checker.sv
dv/testbench.sv
